/* design/unix_seconds_to_civil_date_assert.svh */
// Assertion macros shared by the calendar conversion block.
`ifndef UNIX_SECONDS_TO_CIVIL_DATE_ASSERT_SVH
`define UNIX_SECONDS_TO_CIVIL_DATE_ASSERT_SVH

// Antecedent and consequent in the same cycle.
`define UCD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent in the cycle after the antecedent.
`define UCD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/ucd_pkg.sv */
`default_nettype none

package ucd_pkg;

	// Program counter width.
	localparam int PC_W = 4;

	// Epoch constants.
	localparam logic [11:0] EPOCH_YEAR    = 12'd1970;
	localparam logic [31:0] EPOCH_WEEKDAY = 32'd4;
	localparam logic [1:0]  EPOCH_Y4      = 2'd2;
	localparam logic [6:0]  EPOCH_Y100    = 7'd70;
	localparam logic [8:0]  EPOCH_Y400    = 9'd370;

	// Rounded-up reciprocals for the divisions by a constant. The dividend is
	// first shifted right by the power of two in the divisor: seconds by 7 for
	// 86400 = 128 * 675, hours by 4 for 3600 = 16 * 225, minutes by 2 for
	// 60 = 4 * 15. The product is then shifted right by 35, 19, 21 and 14 bits.
	localparam logic [25:0] RECIP_DAY  = 26'd50903317;
	localparam logic [25:0] RECIP_WEEK = 26'd74899;
	localparam logic [25:0] RECIP_HOUR = 26'd9321;
	localparam logic [25:0] RECIP_MIN  = 26'd1093;

	// Datapath operations, one per control word.
	typedef enum logic [3:0] {
		OP_DIV        = 4'd0,
		OP_SPLIT_DAY  = 4'd1,
		OP_SPLIT_WDAY = 4'd2,
		OP_SPLIT_HOUR = 4'd3,
		OP_SPLIT_MIN  = 4'd4,
		OP_YEAR       = 4'd5,
		OP_MONTH      = 4'd6,
		OP_DONE       = 4'd7
	} op_t;

	// Divisor used by the division and remainder steps.
	typedef enum logic [1:0] {
		DSEL_DAY  = 2'd0,
		DSEL_WEEK = 2'd1,
		DSEL_HOUR = 2'd2,
		DSEL_MIN  = 2'd3
	} divsel_t;

	// Jump conditions.
	typedef enum logic [2:0] {
		COND_NONE  = 3'd0,
		COND_YEAR  = 3'd2,
		COND_MONTH = 3'd3,
		COND_OUT   = 3'd4
	} cond_t;

	// One microcode word.
	typedef struct packed {
		op_t             op;
		divsel_t         dsel;
		cond_t           cond;
		logic [PC_W-1:0] target;
	} ctrl_t;

	// Status flags from the datapath to the sequencer.
	typedef struct packed {
		logic year_ge;
		logic month_ge;
	} status_t;

	// Step addresses.
	localparam logic [PC_W-1:0] PC_DIV_DAY    = 4'd0;
	localparam logic [PC_W-1:0] PC_SPLIT_DAY  = 4'd1;
	localparam logic [PC_W-1:0] PC_DIV_WEEK   = 4'd2;
	localparam logic [PC_W-1:0] PC_SPLIT_WDAY = 4'd3;
	localparam logic [PC_W-1:0] PC_DIV_HOUR   = 4'd4;
	localparam logic [PC_W-1:0] PC_SPLIT_HOUR = 4'd5;
	localparam logic [PC_W-1:0] PC_DIV_MIN    = 4'd6;
	localparam logic [PC_W-1:0] PC_SPLIT_MIN  = 4'd7;
	localparam logic [PC_W-1:0] PC_YEAR       = 4'd8;
	localparam logic [PC_W-1:0] PC_MONTH      = 4'd9;
	localparam logic [PC_W-1:0] PC_DONE       = 4'd10;

	// Divisor value for each select code.
	function automatic logic [16:0] divisor(input divsel_t sel);
		logic [16:0] d;
		case (sel)
			DSEL_DAY:  d = 17'd86400;
			DSEL_WEEK: d = 17'd7;
			DSEL_HOUR: d = 17'd3600;
			DSEL_MIN:  d = 17'd60;
			default:   d = 17'd60;
		endcase
		return d;
	endfunction

	// Length of a month, February following the leap flag.
	function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
		logic [4:0] n;
		case (m)
			4'd2:                  n = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: n = 5'd30;
			default:               n = 5'd31;
		endcase
		return n;
	endfunction

endpackage

`default_nettype wire

/* design/ucd_rom.sv */
`default_nettype none

module ucd_rom
	import ucd_pkg::*;
(
	input  wire logic [PC_W-1:0] pc,
	output ctrl_t                cw
);

	// Conversion program: four divisions, each a quotient step and a remainder
	// step, then the year loop, the month loop and the hand-off.
	always_comb begin
		cw = '{op: OP_DONE, dsel: DSEL_DAY, cond: COND_OUT, target: PC_DONE};
		case (pc)
			PC_DIV_DAY:    cw = '{OP_DIV, DSEL_DAY, COND_NONE, PC_DIV_DAY};
			PC_SPLIT_DAY:  cw = '{OP_SPLIT_DAY, DSEL_DAY, COND_NONE, PC_SPLIT_DAY};
			PC_DIV_WEEK:   cw = '{OP_DIV, DSEL_WEEK, COND_NONE, PC_DIV_WEEK};
			PC_SPLIT_WDAY: cw = '{OP_SPLIT_WDAY, DSEL_WEEK, COND_NONE, PC_SPLIT_WDAY};
			PC_DIV_HOUR:   cw = '{OP_DIV, DSEL_HOUR, COND_NONE, PC_DIV_HOUR};
			PC_SPLIT_HOUR: cw = '{OP_SPLIT_HOUR, DSEL_HOUR, COND_NONE, PC_SPLIT_HOUR};
			PC_DIV_MIN:    cw = '{OP_DIV, DSEL_MIN, COND_NONE, PC_DIV_MIN};
			PC_SPLIT_MIN:  cw = '{OP_SPLIT_MIN, DSEL_MIN, COND_NONE, PC_SPLIT_MIN};
			PC_YEAR:       cw = '{OP_YEAR, DSEL_DAY, COND_YEAR, PC_YEAR};
			PC_MONTH:      cw = '{OP_MONTH, DSEL_DAY, COND_MONTH, PC_MONTH};
			PC_DONE:       cw = '{OP_DONE, DSEL_DAY, COND_OUT, PC_DONE};
			default:       cw = '{OP_DONE, DSEL_DAY, COND_OUT, PC_DONE};
		endcase
	end

endmodule

`default_nettype wire

/* design/ucd_datapath.sv */
`default_nettype none

module ucd_datapath
	import ucd_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              load,
	input  wire logic [31:0]       load_value,
	input  wire logic              exec,
	input  wire ctrl_t             cw,
	output status_t                status,
	output logic [11:0]            year_v,
	output logic [3:0]             month_v,
	output logic [4:0]             day_v,
	output logic [2:0]             weekday_v,
	output logic [4:0]             hour_v,
	output logic [5:0]             minute_v,
	output logic [5:0]             second_v
);

	logic [31:0] num_q;
	logic [15:0] quo_q;
	logic [15:0] days_q;
	logic [16:0] rem_q;
	logic [11:0] year_q;
	logic [1:0]  y4_q;
	logic [6:0]  y100_q;
	logic [8:0]  y400_q;
	logic [3:0]  month_q;
	logic [2:0]  weekday_q;
	logic [4:0]  hour_q;
	logic [5:0]  minute_q;
	logic [5:0]  second_q;

	logic [24:0] mul_a;
	logic [25:0] mul_b;
	logic [50:0] prod;
	logic [15:0] quo_next;
	logic [32:0] back;
	logic [31:0] remain;
	logic        leap;
	logic [8:0]  ylen;
	logic [4:0]  mlen;

	// Reciprocal operands: the dividend without the divisor's power of two.
	always_comb begin
		case (cw.dsel)
			DSEL_DAY: begin
				mul_a = num_q[31:7];
				mul_b = RECIP_DAY;
			end
			DSEL_WEEK: begin
				mul_a = {9'd0, num_q[15:0]};
				mul_b = RECIP_WEEK;
			end
			DSEL_HOUR: begin
				mul_a = {12'd0, num_q[16:4]};
				mul_b = RECIP_HOUR;
			end
			DSEL_MIN: begin
				mul_a = {15'd0, num_q[11:2]};
				mul_b = RECIP_MIN;
			end
			default: begin
				mul_a = {15'd0, num_q[11:2]};
				mul_b = RECIP_MIN;
			end
		endcase
	end

	assign prod = {26'd0, mul_a} * {25'd0, mul_b};

	// The quotient is the product shifted right by the reciprocal's scale.
	always_comb begin
		case (cw.dsel)
			DSEL_DAY:  quo_next = prod[50:35];
			DSEL_WEEK: quo_next = prod[34:19];
			DSEL_HOUR: quo_next = prod[36:21];
			DSEL_MIN:  quo_next = prod[29:14];
			default:   quo_next = prod[29:14];
		endcase
	end

	// Remainder of the dividend after the registered quotient.
	assign back   = {17'd0, quo_q} * {16'd0, divisor(cw.dsel)};
	assign remain = num_q - back[31:0];

	// Leap year from the running remainders of the year by 4, 100 and 400.
	assign leap = (y4_q == 2'd0) && ((y100_q != 7'd0) || (y400_q == 9'd0));
	assign ylen = leap ? 9'd366 : 9'd365;
	assign mlen = month_len(month_q, leap);

	assign status.year_ge  = days_q >= {7'd0, ylen};
	assign status.month_ge = (month_q < 4'd12) && (days_q >= {11'd0, mlen});

	// Datapath registers, updated by the current control word.
	always_ff @(posedge clk) begin
		if (load) begin
			num_q <= load_value;
			quo_q <= '0;
		end else if (exec) begin
			case (cw.op)
				OP_DIV: begin
					quo_q <= quo_next;
				end
				OP_SPLIT_DAY: begin
					days_q <= quo_q;
					rem_q  <= remain[16:0];
					num_q  <= {16'd0, quo_q} + EPOCH_WEEKDAY;
					quo_q  <= '0;
				end
				OP_SPLIT_WDAY: begin
					weekday_q <= remain[2:0];
					num_q     <= {15'd0, rem_q};
					quo_q     <= '0;
				end
				OP_SPLIT_HOUR: begin
					hour_q <= quo_q[4:0];
					num_q  <= remain;
					quo_q  <= '0;
				end
				OP_SPLIT_MIN: begin
					minute_q <= quo_q[5:0];
					second_q <= remain[5:0];
					year_q   <= EPOCH_YEAR;
					y4_q     <= EPOCH_Y4;
					y100_q   <= EPOCH_Y100;
					y400_q   <= EPOCH_Y400;
					month_q  <= 4'd1;
				end
				OP_YEAR: begin
					if (status.year_ge) begin
						days_q <= days_q - {7'd0, ylen};
						year_q <= year_q + 12'd1;
						y4_q   <= y4_q + 2'd1;
						y100_q <= (y100_q == 7'd99) ? 7'd0 : y100_q + 7'd1;
						y400_q <= (y400_q == 9'd399) ? 9'd0 : y400_q + 9'd1;
					end
				end
				OP_MONTH: begin
					if (status.month_ge) begin
						days_q  <= days_q - {11'd0, mlen};
						month_q <= month_q + 4'd1;
					end
				end
				OP_DONE: begin
				end
				default: begin
				end
			endcase
		end
	end

	// Finished fields; the day count left over is the zero-based day of month.
	assign year_v    = year_q;
	assign month_v   = month_q;
	assign day_v     = days_q[4:0] + 5'd1;
	assign weekday_v = weekday_q;
	assign hour_v    = hour_q;
	assign minute_v  = minute_q;
	assign second_v  = second_q;

endmodule

`default_nettype wire

/* design/unix_seconds_to_civil_date.sv */
// Channel  Handshake             Word
// input    in_valid / in_ready   epoch_seconds
// output   out_valid / out_ready year, month, day_of_month, weekday, hour, minute, second
//
// After acceptance a word runs the program, in which Y whole years (0..136) and
// M whole months (0..11), at most 146 together, are stepped off one per cycle. Each of
// the four divisions by a constant is a reciprocal multiply step and a remainder step.
// A new word is taken once the previous result sits in the output register. A stalled
// output holds the sequencer at its last step. Reset clears the sequencer and the output
// valid flag.
`default_nettype none
`include "unix_seconds_to_civil_date_assert.svh"

module unix_seconds_to_civil_date
	import ucd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [31:0] epoch_seconds,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [11:0]      year,
	output logic [3:0]       month,
	output logic [4:0]       day_of_month,
	output logic [2:0]       weekday,
	output logic [4:0]       hour,
	output logic [5:0]       minute,
	output logic [5:0]       second
);

	logic             busy_q;
	logic [PC_W-1:0]  pc_q;
	logic             out_valid_q;
	ctrl_t            cw;
	status_t          status;
	logic             take_jump;
	logic             finish;
	logic             accept;

	logic [11:0] year_v;
	logic [3:0]  month_v;
	logic [4:0]  day_v;
	logic [2:0]  weekday_v;
	logic [4:0]  hour_v;
	logic [5:0]  minute_v;
	logic [5:0]  second_v;

	logic [11:0] year_q;
	logic [3:0]  month_q;
	logic [4:0]  day_q;
	logic [2:0]  weekday_q;
	logic [4:0]  hour_q;
	logic [5:0]  minute_q;
	logic [5:0]  second_q;

	assign in_ready = !busy_q;
	assign accept   = in_valid && in_ready;

	ucd_rom u_rom (
		.pc (pc_q),
		.cw (cw)
	);

	ucd_datapath u_datapath (
		.clk        (clk),
		.load       (accept),
		.load_value (epoch_seconds),
		.exec       (busy_q),
		.cw         (cw),
		.status     (status),
		.year_v     (year_v),
		.month_v    (month_v),
		.day_v      (day_v),
		.weekday_v  (weekday_v),
		.hour_v     (hour_v),
		.minute_v   (minute_v),
		.second_v   (second_v)
	);

	// Conditional jump of the current control word.
	always_comb begin
		case (cw.cond)
			COND_NONE:  take_jump = 1'b0;
			COND_YEAR:  take_jump = status.year_ge;
			COND_MONTH: take_jump = status.month_ge;
			COND_OUT:   take_jump = out_valid_q && !out_ready;
			default:    take_jump = 1'b0;
		endcase
	end

	assign finish = busy_q && (cw.op == OP_DONE) && !take_jump;

	// Step counter and output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			pc_q        <= PC_DIV_DAY;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			if (!busy_q) begin
				pc_q <= PC_DIV_DAY;
				if (in_valid) busy_q <= 1'b1;
			end else if (take_jump) begin
				pc_q <= cw.target;
			end else if (finish) begin
				busy_q      <= 1'b0;
				pc_q        <= PC_DIV_DAY;
				out_valid_q <= 1'b1;
			end else begin
				pc_q <= pc_q + PC_W'(1);
			end
		end
	end

	// Output register: holds the finished word while the next one is worked on.
	always_ff @(posedge clk) begin
		if (finish) begin
			year_q    <= year_v;
			month_q   <= month_v;
			day_q     <= day_v;
			weekday_q <= weekday_v;
			hour_q    <= hour_v;
			minute_q  <= minute_v;
			second_q  <= second_v;
		end
	end

	assign out_valid    = out_valid_q;
	assign year         = year_q;
	assign month        = month_q;
	assign day_of_month = day_q;
	assign weekday      = weekday_q;
	assign hour         = hour_q;
	assign minute       = minute_q;
	assign second       = second_q;

	// The step counter never leaves the program.
	`UCD_ASSERT_IMP(a_pc_range, clk, arst_n, 1'b1, pc_q <= PC_DONE, "pc out of program")
	// An accepted word starts the sequencer.
	`UCD_ASSERT_NEXT(a_start, clk, arst_n, accept, busy_q && pc_q == PC_DIV_DAY, "no start")
	// A finished word is never dropped by the next finish.
	`UCD_ASSERT_IMP(a_no_overrun, clk, arst_n, finish, !out_valid_q || out_ready,
		"result overwritten")
	// Delivered dates and times stay within their calendar ranges.
	`UCD_ASSERT_IMP(a_ranges, clk, arst_n, out_valid,
		month >= 4'd1 && month <= 4'd12 && day_of_month != 5'd0 && weekday <= 3'd6 &&
		hour <= 5'd23 && minute <= 6'd59 && second <= 6'd59, "field out of range")

endmodule

`default_nettype wire

/* test/tb_unix_seconds_to_civil_date.sv */
`timescale 1ns / 100ps

module tb_unix_seconds_to_civil_date;

	localparam int unsigned SEC_PER_DAY  = 86400;
	localparam int unsigned SEC_PER_HOUR = 3600;
	localparam int unsigned SEC_PER_MIN  = 60;
	localparam int unsigned EPOCH_YR     = 1970;
	localparam int unsigned EPOCH_WDAY   = 4;
	localparam int unsigned MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

	localparam int HOLD_CYCLES  = 1500;
	localparam int DRAIN_CYCLES = 250;
	localparam int CYCLE_LIMIT  = 1000000;

	// Calendar edges: epoch, minute/hour/day rollovers, end of the first year,
	// leap days of 1972 and 2000, the turn of the century, the non-leap 2100
	// February, the signed 32-bit overflow point, alternating bits and the top.
	localparam logic [31:0] CALENDAR_EDGES [24] = '{
		32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
		32'd31535999, 32'd31536000, 32'd68169600, 32'd94694399,
		32'd946684799, 32'd946684800, 32'd951782400, 32'd951868799,
		32'd4107542399, 32'd4107542400, 32'd2147483647, 32'd2147483648,
		32'h55555555, 32'hAAAAAAAA, 32'hFFFFFFFE, 32'hFFFFFFFF
	};

	typedef struct packed {
		logic [11:0] year;
		logic [3:0]  month;
		logic [4:0]  day_of_month;
		logic [2:0]  weekday;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
	} civil_t;

	typedef struct packed {
		logic [31:0] secs;
		civil_t      date;
	} dated_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [31:0] epoch_seconds = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [11:0] year;
	logic [3:0]  month;
	logic [4:0]  day_of_month;
	logic [2:0]  weekday;
	logic [4:0]  hour;
	logic [5:0]  minute;
	logic [5:0]  second;

	dated_word_t pending_dates [$];
	dated_word_t want;
	civil_t      got;
	bit          steady = 1'b0;
	bit          hold_req = 1'b0;
	int          hold_cnt = 0;
	int          cycle_count = 0;
	int          words_sent = 0;
	int          words_checked = 0;
	int          mismatches = 0;

	unix_seconds_to_civil_date i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.epoch_seconds(epoch_seconds),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.year         (year),
		.month        (month),
		.day_of_month (day_of_month),
		.weekday      (weekday),
		.hour         (hour),
		.minute       (minute),
		.second       (second)
	);

	always #5 clk = ~clk;

	// Full Gregorian rule: every fourth year, except centuries not divisible by 400.
	function automatic bit leap_year(input int unsigned yr);
		return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
	endfunction

	function automatic int unsigned days_in_year(input int unsigned yr);
		return leap_year(yr) ? 366 : 365;
	endfunction

	function automatic int unsigned days_in_month(input int unsigned yr, input int unsigned mo);
		return (mo == 2 && leap_year(yr)) ? 29 : MONTH_DAYS[mo - 1];
	endfunction

	// Expected civil date: strip whole years, then whole months, off the day count.
	function automatic civil_t civil_from_seconds(input logic [31:0] secs);
		civil_t      c;
		int unsigned days;
		int unsigned rem;
		int unsigned yr;
		int unsigned mo;
		days = secs / SEC_PER_DAY;
		rem  = secs % SEC_PER_DAY;
		yr   = EPOCH_YR;
		mo   = 1;
		c.weekday = 3'((days + EPOCH_WDAY) % 7);
		while (days >= days_in_year(yr)) begin
			days -= days_in_year(yr);
			yr++;
		end
		while (mo < 12 && days >= days_in_month(yr, mo)) begin
			days -= days_in_month(yr, mo);
			mo++;
		end
		c.year         = 12'(yr);
		c.month        = 4'(mo);
		c.day_of_month = 5'(days + 1);
		c.hour         = 5'(rem / SEC_PER_HOUR);
		c.minute       = 6'((rem % SEC_PER_HOUR) / SEC_PER_MIN);
		c.second       = 6'(rem % SEC_PER_MIN);
		return c;
	endfunction

	// Seconds at midnight on the first day of the given month.
	function automatic longint unsigned month_start(input int unsigned yr, input int unsigned mo);
		longint unsigned days;
		int unsigned     y;
		int unsigned     m;
		days = 0;
		for (y = EPOCH_YR; y < yr; y++)
			days += days_in_year(y);
		for (m = 1; m < mo; m++)
			days += days_in_month(yr, m);
		return days * SEC_PER_DAY;
	endfunction

	// Random time stamp: uniform, around midnight, around a month start,
	// inside the first two years or inside the last two years of the range.
	function automatic logic [31:0] random_seconds();
		longint unsigned v;
		v = 0;
		case ($urandom_range(9))
			0, 1, 2, 3: v = $urandom;
			4, 5: begin
				v = longint'($urandom_range(49710)) * SEC_PER_DAY;
				if ($urandom_range(1))
					v += $urandom_range(3);
				else
					v += SEC_PER_DAY - 1 - $urandom_range(3);
			end
			6, 7: begin
				v = month_start($urandom_range(2106, 1970), $urandom_range(12, 1));
				if ($urandom_range(1) || v < 120)
					v += $urandom_range(119);
				else
					v -= 1 + $urandom_range(119);
			end
			8: v = $urandom_range(63072000);
			default: v = 64'hFFFFFFFF - $urandom_range(63072000);
		endcase
		if (v > 64'hFFFFFFFF)
			v = 64'hFFFFFFFF - $urandom_range(999);
		return v[31:0];
	endfunction

	// Offer one word, with random gaps ahead of it unless idling is off.
	task automatic send_word(input logic [31:0] secs);
		dated_word_t w;
		@(negedge clk);
		while (!steady && $urandom_range(99) < 8) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid      <= 1'b1;
		epoch_seconds <= secs;
		do
			@(posedge clk);
		while (!in_ready);
		w.secs = secs;
		w.date = civil_from_seconds(secs);
		pending_dates.push_back(w);
		words_sent++;
	endtask

	task automatic drop_valid();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	task automatic test_calendar_edges();
		foreach (CALENDAR_EDGES[i])
			send_word(CALENDAR_EDGES[i]);
		drop_valid();
	endtask

	task automatic test_back_to_back();
		steady = 1'b1;
		repeat (150)
			send_word(random_seconds());
		drop_valid();
		steady = 1'b0;
	endtask

	task automatic test_random_gaps(input int count);
		repeat (count)
			send_word(random_seconds());
		drop_valid();
	endtask

	// The receiver stops for a long time while words keep coming, so the
	// block fills up and must deassert in_ready.
	task automatic test_output_hold();
		hold_req = 1'b1;
		repeat (10)
			send_word(random_seconds());
		drop_valid();
		while (hold_req || hold_cnt != 0)
			@(negedge clk);
	endtask

	// Receiver: random stalls, a stall-free mode and the long hold-off.
	always @(negedge clk) begin
		if (hold_cnt != 0) begin
			out_ready <= 1'b0;
			hold_cnt  <= hold_cnt - 1;
		end else if (hold_req) begin
			out_ready <= 1'b0;
			hold_cnt  <= HOLD_CYCLES - 1;
			hold_req = 1'b0;
		end else if (steady) begin
			out_ready <= 1'b1;
		end else begin
			out_ready <= ($urandom_range(99) >= 8);
		end
	end

	// Check every accepted result against the oldest outstanding word.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			got = '{year, month, day_of_month, weekday, hour, minute, second};
			if (pending_dates.size() == 0) begin
				if (mismatches < 10)
					$display("Unexpected result %0d-%0d-%0d wd%0d %0d:%0d:%0d",
						got.year, got.month, got.day_of_month, got.weekday,
						got.hour, got.minute, got.second);
				mismatches++;
			end else begin
				want = pending_dates.pop_front();
				words_checked++;
				if (got.year !== want.date.year || got.month !== want.date.month ||
						got.day_of_month !== want.date.day_of_month ||
						got.weekday !== want.date.weekday || got.hour !== want.date.hour ||
						got.minute !== want.date.minute || got.second !== want.date.second) begin
					if (mismatches < 10)
						$display("Mismatch for %0d: expected %0d-%0d-%0d wd%0d %0d:%0d:%0d, got %0d-%0d-%0d wd%0d %0d:%0d:%0d",
							want.secs, want.date.year, want.date.month,
							want.date.day_of_month, want.date.weekday, want.date.hour,
							want.date.minute, want.date.second, got.year, got.month,
							got.day_of_month, got.weekday, got.hour, got.minute, got.second);
					mismatches++;
				end
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		repeat (10)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_calendar_edges();
		test_back_to_back();
		test_random_gaps(500);
		test_output_hold();
		test_random_gaps(366);

		// Let every outstanding word come back, then watch for strays.
		while (pending_dates.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);

		$display("Converted %0d of %0d words: calendar edges, random times near midnight,",
			words_checked, words_sent);
		$display("month and range ends, gaps on both sides and a %0d-cycle output hold.",
			HOLD_CYCLES);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
